// ----- hw/rtl/soalu_pkg.sv -----
// Package for the shifted-operand integer ALU: field widths, opcodes, stage structs.
// Used by soalu_divider and shifted_operand_integer_alu_unit.
package soalu_pkg;
   localparam int WordBits = 64;
   localparam int AmtBits  = 6;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_SHL  = 2'd1;
   localparam logic [1:0] MODE_SHR  = 2'd2;
   localparam logic [1:0] MODE_SAR  = 2'd3;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_DIV  = 4'd3;
   localparam logic [3:0] OP_MOD  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_OR   = 4'd6;
   localparam logic [3:0] OP_XOR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd8;
   localparam logic [3:0] OP_SHL  = 4'd9;
   localparam logic [3:0] OP_SHR  = 4'd10;
   localparam logic [3:0] OP_SAR  = 4'd11;
   localparam logic [3:0] OP_ROL  = 4'd12;
   localparam logic [3:0] OP_ROR  = 4'd13;
   localparam logic [3:0] OP_NOP0 = 4'd14;
   localparam logic [3:0] OP_NOP1 = 4'd15;

   // item riding the divider pipeline
   typedef struct packed {
      logic                  valid;
      logic                  is_mod;
      logic [WordBits-1:0]   rem;
      logic [WordBits-1:0]   quo;   // dividend shifts out, quotient shifts in
      logic [WordBits-1:0]   dsr;
      logic [WordBits-1:0]   side;  // result of a non-divide op
      logic                  we;
      logic                  fault;
      logic                  is_div;
   } div_stage_type;

   function automatic logic [WordBits-1:0] shift_sat(
      input logic [WordBits-1:0] x, input logic [WordBits-1:0] n,
      input logic [1:0] mode);
      logic [WordBits-1:0] fill;
      logic                big;
      logic [AmtBits-1:0]  k;
      begin
         fill = (mode == MODE_SAR && x[WordBits-1]) ? '1 : '0;
         big  = (n[WordBits-1:AmtBits] != '0);
         k    = n[AmtBits-1:0];
         unique case (mode)
            MODE_SHL: shift_sat = big ? '0 : (x << k);
            MODE_SHR: shift_sat = big ? '0 : (x >> k);
            MODE_SAR: shift_sat = big ? fill : WordBits'($signed(x) >>> k);
            default:  shift_sat = x;
         endcase
      end
   endfunction
endpackage

// ----- hw/rtl/shifted_operand_integer_alu_unit.sv -----
// Top level of the shifted-operand 64-bit integer ALU.
// Uses soalu_pkg and soalu_divider.
//
// Usage:
//   req_ channel carries one operation per item: pre-shift mode, opcode,
//   pre-shift distance and two 64-bit operands. rsp_ channel returns one
//   result per item: value, write enable and divide fault, in order.
//   From req accept to rsp valid an item passes the pre-shift stage, the
//   operate stage (products in 32x32 partial products), 16 divider stages
//   at four quotient bits each (the product sum joins the first of them),
//   and the output register.
//   Throughput is one item per cycle; the radix-16 divider pipeline sets
//   the depth. The whole pipe advances as one when the output register is
//   empty or being taken, so a stalled rsp_ side holds every stage and
//   req_tready drops; nothing is lost or repeated.
//   Reset clears all stage valid bits; payload registers are not reset.
module shifted_operand_integer_alu_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] shift_mode, [5:2] alu_op, [11:6] shift_amount,
   // [75:12] left_value, [139:76] right_value, [143:140] zero
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] result_value, [64] write_enable, [65] divide_fault, [71:66] zero
   output logic [71:0]  rsp_tdata
);
   import soalu_pkg::*;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: pre-shift
   logic                v1_ff;
   logic [3:0]          op1_ff;
   logic [WordBits-1:0] a1_ff, b1_ff;
   logic [WordBits-1:0] b1_in;
   assign b1_in = shift_sat(req_tdata[139:76], {58'd0, req_tdata[11:6]}, req_tdata[1:0]);

   // stage 2: operate, partial products
   logic                v2_ff, div2_ff, mod2_ff, we2_ff, flt2_ff, mul2_ff;
   logic [WordBits-1:0] r2_ff, a2_ff, b2_ff;
   logic [63:0]         pll_ff;
   logic [31:0]         plh_ff, phl_ff;
   logic [WordBits-1:0] r2_in;
   logic                we2_in, flt2_in, zero_b;
   logic [AmtBits-1:0]  rk;
   assign zero_b = (b1_ff == '0);
   assign rk     = b1_ff[AmtBits-1:0];

   always_comb begin
      r2_in   = '0;
      we2_in  = 1'b1;
      flt2_in = 1'b0;
      case (op1_ff) inside
         OP_ADD: r2_in = a1_ff + b1_ff;
         OP_SUB: r2_in = a1_ff - b1_ff;
         OP_AND: r2_in = a1_ff & b1_ff;
         OP_OR:  r2_in = a1_ff | b1_ff;
         OP_XOR: r2_in = a1_ff ^ b1_ff;
         OP_NOT: r2_in = ~b1_ff;
         OP_SHL: r2_in = shift_sat(a1_ff, b1_ff, MODE_SHL);
         OP_SHR: r2_in = shift_sat(a1_ff, b1_ff, MODE_SHR);
         OP_SAR: r2_in = shift_sat(a1_ff, b1_ff, MODE_SAR);
         OP_ROL: r2_in = (a1_ff << rk) | (a1_ff >> (7'(WordBits) - {1'b0, rk}));
         OP_ROR: r2_in = (a1_ff >> rk) | (a1_ff << (7'(WordBits) - {1'b0, rk}));
         OP_DIV, OP_MOD: begin
            we2_in  = !zero_b;
            flt2_in = zero_b;
         end
         OP_NOP0, OP_NOP1: we2_in = 1'b0;
         default: r2_in = '0;
      endcase
   end

   // stage 3: product sum, divider entry
   div_stage_type d_in, d_out;
   always_comb begin
      d_in.valid  = v2_ff;
      d_in.is_mod = mod2_ff;
      d_in.is_div = div2_ff && !flt2_ff;
      d_in.rem    = '0;
      d_in.quo    = a2_ff;
      d_in.dsr    = b2_ff;
      d_in.we     = we2_ff;
      d_in.fault  = flt2_ff;
      d_in.side   = mul2_ff ? (pll_ff + {plh_ff + phl_ff, 32'd0}) : r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff  <= req_tvalid;
         op1_ff <= req_tdata[5:2];
         a1_ff  <= req_tdata[75:12];
         b1_ff  <= b1_in;

         v2_ff   <= v1_ff;
         div2_ff <= (op1_ff == OP_DIV) || (op1_ff == OP_MOD);
         mod2_ff <= (op1_ff == OP_MOD);
         mul2_ff <= (op1_ff == OP_MUL);
         we2_ff  <= we2_in;
         flt2_ff <= flt2_in;
         r2_ff   <= r2_in;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         pll_ff  <= a1_ff[31:0] * b1_ff[31:0];
         plh_ff  <= 32'(a1_ff[31:0] * b1_ff[63:32]);
         phl_ff  <= 32'(a1_ff[63:32] * b1_ff[31:0]);
      end
   end

   soalu_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage_in  (d_in),
      .stage_out (d_out)
   );

   logic                vo_ff, weo_ff, flto_ff;
   logic [WordBits-1:0] ro_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff   <= d_out.valid;
         weo_ff  <= d_out.we;
         flto_ff <= d_out.fault;
         ro_ff   <= d_out.fault ? '0 :
                    (d_out.is_div ? (d_out.is_mod ? d_out.rem : d_out.quo) : d_out.side);
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {6'd0, flto_ff, weo_ff, ro_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_fault_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> !rsp_tdata[64] && rsp_tdata[63:0] == '0)
      else $error("divide fault with write");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready not tied to output advance");
endmodule

// ----- hw/rtl/soalu_divider.sv -----
// Restoring divider pipeline, four quotient bits per stage, 16 stages; the
// output register sits in the top level. Uses soalu_pkg. Advances only when enabled.
module soalu_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  soalu_pkg::div_stage_type     stage_in,
   output soalu_pkg::div_stage_type     stage_out
);
   import soalu_pkg::*;

   localparam int BitsPerStage = 4;
   localparam int Stages       = WordBits / BitsPerStage;

   div_stage_type pipe_ff [Stages];
   div_stage_type step_in [Stages];

   function automatic div_stage_type div_steps(input div_stage_type s);
      div_stage_type t;
      logic [WordBits:0] trial;
      begin
         t = s;
         for (int i = 0; i < BitsPerStage; i++) begin
            trial = {t.rem, t.quo[WordBits-1]} - {1'b0, t.dsr};
            if (!trial[WordBits]) begin
               t.rem = trial[WordBits-1:0];
               t.quo = {t.quo[WordBits-2:0], 1'b1};
            end else begin
               t.rem = {t.rem[WordBits-2:0], t.quo[WordBits-1]};
               t.quo = {t.quo[WordBits-2:0], 1'b0};
            end
         end
         div_steps = t;
      end
   endfunction

   always_comb begin
      step_in[0] = div_steps(stage_in);
      for (int i = 1; i < Stages; i++) begin
         step_in[i] = div_steps(pipe_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Stages; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 0; i < Stages; i++) begin
            pipe_ff[i] <= step_in[i];
         end
      end
   end

   assign stage_out = pipe_ff[Stages-1];
endmodule
